// File: src/lfu_slot_replacement_top_defines.svh
// assertion macros shared by the lfu slot replacement rtl
`ifndef LFU_SLOT_REPLACEMENT_TOP_DEFINES_SVH
`define LFU_SLOT_REPLACEMENT_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// clocked check, switched off while reset is asserted
`define LFU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFU_ASSERT(lbl, prop, msg)
`define LFU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: src/lfu_sr_pkg.sv
// constants shared by the lfu slot replacement block
package lfu_sr_pkg;

    // fixed port widths
    localparam int CAND_W  = 8;
    localparam int EVID_W  = 8;
    localparam int SLOT_W  = 5;
    localparam int OCC_W   = 6;
    localparam int CFG_W   = 6;

    // insertion stamp width
    localparam int STAMP_BITS = 32;

    // slot limit after reset
    localparam logic [CFG_W-1:0] LIMIT_RESET = 6'd20;

endpackage

// File: src/lfu_sr_ram.sv
// generic single write port ram with registered read
module lfu_sr_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 32
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: src/lfu_slot_replacement_top.sv
// top level of the lfu slot replacement table
//
// least-frequently-used slot table, oldest insertion evicted on equal counts.
// a transaction is taken at a rising edge with start high and busy low. the
// block then walks every slot through the single read port of the entry ram,
// one slot per cycle, tracking the first id match, the lowest free slot and
// the least-count oldest victim. a write-back state then writes the updated
// or new entry back. the result shows for exactly one cycle with done high
// and must be taken then: there is no way to hold it off. busy stays high
// from the taken transaction through the slot walk and the write-back, so
// a new item is not taken before the last one is written back. valid bits
// sit in flip-flops cleared by reset, so no clearing pass is needed and the
// block is ready straight after reset. the slot limit register is written
// over the cfg channel, always ready, and should only change while the block
// is idle.
`include "lfu_slot_replacement_top_defines.svh"

module lfu_slot_replacement_top #(
    parameter int MAX_SLOTS  = 32,
    parameter int ID_BITS    = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // item command
    input  logic                                start,
    output logic                                busy,
    input  logic [lfu_sr_pkg::CAND_W-1:0]       candidate_id,
    // slot limit register
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lfu_sr_pkg::CFG_W-1:0]        cfg_data,
    // result
    output logic                                done,
    output logic                                hit,
    output logic                                evicted,
    output logic [lfu_sr_pkg::EVID_W-1:0]       evicted_id,
    output logic [lfu_sr_pkg::SLOT_W-1:0]       slot_used,
    output logic [lfu_sr_pkg::OCC_W-1:0]        occupancy
);

    localparam int SB = lfu_sr_pkg::STAMP_BITS;
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int EW = ID_BITS + COUNT_BITS + SB;
    localparam int LW = 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CW-1:0]         SCAN_END  = CW'(MAX_SLOTS);
    localparam logic [LW-1:0]         LIM_MAX   = LW'(MAX_SLOTS);

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    // control state
    logic [1:0]                 state_reg,   state_next;
    logic [CW-1:0]              cnt_reg,     cnt_next;
    logic [MAX_SLOTS-1:0]       valid_reg,   valid_next;
    logic [CW-1:0]              occ_reg,     occ_next;
    logic [SB-1:0]              clock_reg,   clock_next;
    logic [lfu_sr_pkg::CFG_W-1:0] limit_reg, limit_next;
    logic                       done_reg,    done_next;
    logic                       mfound_reg,  mfound_next;
    logic                       vfound_reg,  vfound_next;
    logic                       ffound_reg,  ffound_next;

    // payload, no reset
    logic [ID_BITS-1:0]         id_reg,      id_next;
    logic [SW-1:0]              midx_reg,    midx_next;
    logic [COUNT_BITS-1:0]      mcnt_reg,    mcnt_next;
    logic [SB-1:0]              mstamp_reg,  mstamp_next;
    logic [SW-1:0]              vidx_reg,    vidx_next;
    logic [COUNT_BITS-1:0]      vcnt_reg,    vcnt_next;
    logic [SB-1:0]              vstamp_reg,  vstamp_next;
    logic [ID_BITS-1:0]         vid_reg,     vid_next;
    logic [SW-1:0]              fidx_reg,    fidx_next;
    logic                       hit_reg,     hit_next;
    logic                       ev_reg,      ev_next;
    logic [ID_BITS-1:0]         evid_reg,    evid_next;
    logic [SW-1:0]              slot_reg,    slot_next;

    // ram port
    logic                       ram_we;
    logic [SW-1:0]              ram_waddr;
    logic [EW-1:0]              ram_wdata;
    logic [SW-1:0]              ram_raddr;
    logic [EW-1:0]              ram_rdata;

    // entry under evaluation
    logic                       eval_on;
    logic [SW-1:0]              eval_idx;
    logic                       eval_valid;
    logic [ID_BITS-1:0]         e_id;
    logic [COUNT_BITS-1:0]      e_cnt;
    logic [SB-1:0]              e_stamp;

    // write-back decisions
    logic [LW-1:0]              lim_raw;
    logic [LW-1:0]              lim;
    logic                       full;
    logic                       do_evict;
    logic [SW-1:0]              target;
    logic [COUNT_BITS-1:0]      cnt_inc;

    lfu_sr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SLOTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // slot walk: read address leads evaluation, which uses the registered ram output
    assign ram_raddr  = cnt_reg[SW-1:0];
    assign eval_on    = (state_reg == ST_SCAN) && (cnt_reg != '0);
    assign eval_idx   = SW'(cnt_reg - CW'(1));
    assign eval_valid = valid_reg[eval_idx];
    assign e_id       = ram_rdata[EW-1 -: ID_BITS];
    assign e_cnt      = ram_rdata[COUNT_BITS+SB-1 -: COUNT_BITS];
    assign e_stamp    = ram_rdata[SB-1:0];

    // slot limit clamped to 1..MAX_SLOTS
    assign lim_raw  = (limit_reg == '0) ? LW'(1) : LW'(limit_reg);
    assign lim      = (lim_raw > LIM_MAX) ? LIM_MAX : lim_raw;
    assign full     = (LW'(occ_reg) >= lim);

    assign do_evict = !mfound_reg && (full || !ffound_reg);
    assign target   = mfound_reg ? midx_reg : (do_evict ? vidx_reg : fidx_reg);
    assign cnt_inc  = (mcnt_reg == COUNT_MAX) ? mcnt_reg : mcnt_reg + COUNT_BITS'(1);

    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_waddr = target;
    assign ram_wdata = mfound_reg ? {id_reg, cnt_inc, mstamp_reg}
                                  : {id_reg, COUNT_BITS'(1), clock_reg};

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg;
        occ_next    = occ_reg;
        clock_next  = clock_reg;
        limit_next  = limit_reg;
        done_next   = 1'b0;
        mfound_next = mfound_reg;
        vfound_next = vfound_reg;
        ffound_next = ffound_reg;
        id_next     = id_reg;
        midx_next   = midx_reg;
        mcnt_next   = mcnt_reg;
        mstamp_next = mstamp_reg;
        vidx_next   = vidx_reg;
        vcnt_next   = vcnt_reg;
        vstamp_next = vstamp_reg;
        vid_next    = vid_reg;
        fidx_next   = fidx_reg;
        hit_next    = hit_reg;
        ev_next     = ev_reg;
        evid_next   = evid_reg;
        slot_next   = slot_reg;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        // fold in the entry read last cycle
        if (eval_on)
        begin
            if (eval_valid)
            begin
                if (!mfound_reg && (e_id == id_reg))
                begin
                    mfound_next = 1'b1;
                    midx_next   = eval_idx;
                    mcnt_next   = e_cnt;
                    mstamp_next = e_stamp;
                end
                if (!vfound_reg || (e_cnt < vcnt_reg) ||
                    ((e_cnt == vcnt_reg) && (e_stamp < vstamp_reg)))
                begin
                    vfound_next = 1'b1;
                    vidx_next   = eval_idx;
                    vcnt_next   = e_cnt;
                    vstamp_next = e_stamp;
                    vid_next    = e_id;
                end
            end
            else if (!ffound_reg)
            begin
                ffound_next = 1'b1;
                fidx_next   = eval_idx;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next  = ST_SCAN;
                    cnt_next    = '0;
                    id_next     = ID_BITS'(candidate_id);
                    mfound_next = 1'b0;
                    vfound_next = 1'b0;
                    ffound_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == SCAN_END)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_WRITE:
            begin
                state_next        = ST_IDLE;
                valid_next[target] = 1'b1;
                if (!mfound_reg && !do_evict)
                begin
                    occ_next = occ_reg + CW'(1);
                end
                clock_next = clock_reg + SB'(1);
                done_next  = 1'b1;
                hit_next   = mfound_reg;
                ev_next    = do_evict;
                evid_next  = do_evict ? vid_reg : '0;
                slot_next  = target;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            valid_reg  <= '0;
            occ_reg    <= '0;
            clock_reg  <= '0;
            limit_reg  <= lfu_sr_pkg::LIMIT_RESET;
            done_reg   <= 1'b0;
            mfound_reg <= 1'b0;
            vfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            valid_reg  <= valid_next;
            occ_reg    <= occ_next;
            clock_reg  <= clock_next;
            limit_reg  <= limit_next;
            done_reg   <= done_next;
            mfound_reg <= mfound_next;
            vfound_reg <= vfound_next;
            ffound_reg <= ffound_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg     <= id_next;
        midx_reg   <= midx_next;
        mcnt_reg   <= mcnt_next;
        mstamp_reg <= mstamp_next;
        vidx_reg   <= vidx_next;
        vcnt_reg   <= vcnt_next;
        vstamp_reg <= vstamp_next;
        vid_reg    <= vid_next;
        fidx_reg   <= fidx_next;
        hit_reg    <= hit_next;
        ev_reg     <= ev_next;
        evid_reg   <= evid_next;
        slot_reg   <= slot_next;
    end

    // ports
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign hit        = hit_reg;
    assign evicted    = ev_reg;
    assign evicted_id = lfu_sr_pkg::EVID_W'(evid_reg);
    assign slot_used  = lfu_sr_pkg::SLOT_W'(slot_reg);
    assign occupancy  = lfu_sr_pkg::OCC_W'(occ_reg);

    // checks
    `LFU_ASSERT(a_done_after_write, done_reg |-> $past(state_reg == ST_WRITE), "done without write-back")
    `LFU_ASSERT(a_occ_bound, occ_reg <= SCAN_END, "occupancy beyond table size")
    `LFU_ASSERT(a_hit_no_evict, done_reg |-> !(hit_reg && ev_reg), "hit and eviction together")
    `LFU_ASSERT(a_evict_keeps_occ, (done_reg && ev_reg) |-> (occ_reg == $past(occ_reg)), "eviction changed occupancy")
    `LFU_ASSERT(a_write_after_full_walk, (state_reg == ST_WRITE) |-> (cnt_reg == SCAN_END), "write-back before walk ended")

endmodule
